// ----- hdl/c7s_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c7s_pkg: shared types, constants and microcode for the counter display
// Holds the segment table, the grid layout constants and the control store
// of the conversion sequencer.
// ----------------------------------------------------------------------------
package c7s_pkg;

    localparam int unsigned POSITIONS   = 6;
    localparam int unsigned SEG_COUNT   = 7;
    localparam int unsigned GRID_BYTES  = 14;
    localparam int unsigned EVEN_POS    = 5;

    localparam logic [3:0] BLANK_CODE = 4'd10;
    localparam logic [3:0] LAST_ADDR  = 4'(GRID_BYTES - 1);

    // Reciprocal of ten: floor(n * MAGIC / 2^35) == n / 10 for any n below 2^32
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

    // Bit driven by each of digit positions 0..4 inside an even grid byte
    localparam int unsigned POS_BIT_IDX [EVEN_POS] = '{2, 3, 4, 5, 7};

    typedef logic [POSITIONS-1:0][3:0] digit_vec_t;
    typedef logic [2:0]                step_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CONV_DONE,
        COND_MORE_BYTES
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  mul;
        logic  div;
        logic  finish;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam step_t STEP_ACCEPT = 3'd0;
    localparam step_t STEP_MUL    = 3'd1;
    localparam step_t STEP_DIV    = 3'd2;
    localparam step_t STEP_FINISH = 3'd3;
    localparam step_t STEP_EMIT   = 3'd4;
    localparam step_t STEP_RETURN = 3'd5;

    // Control store of the sequencer
    function automatic ctrl_word_t ctrl_rom(input step_t step);
        ctrl_word_t cw;
        cw        = '0;
        cw.cond   = COND_NEVER;
        cw.target = STEP_ACCEPT;
        case (step)
            STEP_ACCEPT:
            begin
                cw.accept = 1'b1;
            end
            STEP_MUL:
            begin
                cw.mul    = 1'b1;
                cw.cond   = COND_CONV_DONE;
                cw.target = STEP_FINISH;
            end
            STEP_DIV:
            begin
                cw.div    = 1'b1;
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_MUL;
            end
            STEP_FINISH:
            begin
                cw.finish = 1'b1;
            end
            STEP_EMIT:
            begin
                cw.emit   = 1'b1;
                cw.cond   = COND_MORE_BYTES;
                cw.target = STEP_EMIT;
            end
            STEP_RETURN:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_ACCEPT;
            end
            default:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_ACCEPT;
            end
        endcase
        return cw;
    endfunction

    // Segment k of a digit is bit k; blank and unused codes light nothing
    function automatic logic [SEG_COUNT-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_COUNT-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h7E;
            4'd1:    pat = 7'h30;
            4'd2:    pat = 7'h6D;
            4'd3:    pat = 7'h79;
            4'd4:    pat = 7'h33;
            4'd5:    pat = 7'h5B;
            4'd6:    pat = 7'h5F;
            4'd7:    pat = 7'h70;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h7B;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/c7s_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c7s_if: channel interfaces of the counter display
// Valid/ready channels for the counter input and the grid byte output.
// ----------------------------------------------------------------------------
interface c7s_count_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] count_value;

    modport source (output valid, output count_value, input ready);
    modport sink   (input valid, input count_value, output ready);
endinterface

interface c7s_grid_if;
    logic       valid;
    logic       ready;
    logic [3:0] grid_address;
    logic [7:0] grid_byte;
    logic       last_byte;
    logic       overflow;

    modport source (output valid, output grid_address, output grid_byte,
                    output last_byte, output overflow, input ready);
    modport sink   (input valid, input grid_address, input grid_byte,
                    input last_byte, input overflow, output ready);
endinterface

// ----- hdl/c7s_grid_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c7s_grid_map: digit to grid byte transposition
// Builds one display RAM byte from the six digit codes and the byte address.
// ----------------------------------------------------------------------------
module c7s_grid_map (
    input  c7s_pkg::digit_vec_t digits,
    input  logic [3:0]          grid_address,
    output logic [7:0]          grid_byte
);
    import c7s_pkg::*;

    logic [2:0] seg_idx;

    assign seg_idx = grid_address[3:1];

    always_comb
    begin
        logic [SEG_COUNT-1:0] pat;
        grid_byte = '0;
        if (grid_address[0])
        begin
            // odd byte: only the top position, on bit 0
            pat          = seg_pattern(digits[POSITIONS-1]);
            grid_byte[0] = pat[seg_idx];
        end
        else
        begin
            for (int p = 0; p < EVEN_POS; p++)
            begin
                pat                         = seg_pattern(digits[p]);
                grid_byte[POS_BIT_IDX[p]]   = pat[seg_idx];
            end
        end
    end

endmodule

// ----- hdl/counter_to_seven_segment_grid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_to_seven_segment_grid: counter value to seven-segment grid image
// Converts a signed counter to decimal digits and streams the 14-byte
// display RAM image, one byte per transaction.
// ----------------------------------------------------------------------------
// One counter value in gives fourteen grid bytes out, addresses 0 to 13 in
// order, with last_byte on address 13. Zero and negative values show a single
// 0; leading positions are blank. Values with more than DIGIT_COUNT digits
// show their low digits unblanked and flag overflow on all fourteen bytes.
// A small microcoded sequencer runs the work: an accept step takes the value,
// each decimal digit takes a multiply step and a divide step through a shared
// divide-by-ten unit (multiply by reciprocal, then remainder), a last multiply
// step tests for the end, then come a finishing step, one emit step per grid
// byte and a return step; at most DIGIT_COUNT digits are extracted. The emit
// steps hold while the output register is not taken. A new value is taken
// while the last byte still waits.
// ----------------------------------------------------------------------------
module counter_to_seven_segment_grid #(
    parameter int DIGIT_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    c7s_count_if.sink   count_in,
    c7s_grid_if.source  grid_out
);
    import c7s_pkg::*;

    localparam logic [2:0] DIGIT_LIMIT = 3'(DIGIT_COUNT);

    // sequencer
    step_t      step_reg, step_next;
    ctrl_word_t cw;
    logic       stall;
    logic       cond_true;
    logic       conv_done;

    // datapath
    logic [30:0] value_reg;
    logic [62:0] prod_reg;
    logic [27:0] quot;
    logic [30:0] quot_x10;
    logic [3:0]  rem;
    digit_vec_t  digit_reg;
    logic [2:0]  used_reg;
    logic [3:0]  byte_reg;
    logic        ovf_reg;
    logic [7:0]  map_byte;

    // output register
    logic        out_valid_reg;
    logic [3:0]  out_address_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_ovf_reg;

    logic in_fire;

    assign cw        = ctrl_rom(step_reg);
    assign conv_done = (value_reg == '0) || (used_reg == DIGIT_LIMIT);

    // hold on a missing input or a full, untaken output register
    assign stall = (cw.accept && !count_in.valid) ||
                   (cw.emit && out_valid_reg && !grid_out.ready);

    assign count_in.ready = cw.accept;
    assign in_fire        = count_in.valid && cw.accept;

    always_comb
    begin
        case (cw.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_CONV_DONE:  cond_true = conv_done;
            COND_MORE_BYTES: cond_true = (byte_reg != LAST_ADDR);
            default:         cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (!stall)
        begin
            step_next = cond_true ? cw.target : step_t'(step_reg + 3'd1);
        end
    end

    // divide by ten: quotient from the registered product, remainder by shift-add
    assign quot     = prod_reg[62:DIV10_SHIFT];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem      = 4'(value_reg - quot_x10);

    c7s_grid_map u_grid_map (
        .digits       (digit_reg),
        .grid_address (byte_reg),
        .grid_byte    (map_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_ACCEPT;
            used_reg      <= '0;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            if (in_fire)
            begin
                used_reg <= '0;
            end
            else if (cw.div)
            begin
                used_reg <= used_reg + 3'd1;
            end

            if (cw.finish)
            begin
                byte_reg <= '0;
            end
            else if (cw.emit && !stall)
            begin
                byte_reg <= byte_reg + 4'd1;
            end

            if (cw.emit && !stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (grid_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            // negative counts as zero
            value_reg <= count_in.count_value[31] ? '0 : count_in.count_value[30:0];
            for (int p = 0; p < POSITIONS; p++)
            begin
                digit_reg[p] <= BLANK_CODE;
            end
        end

        if (cw.mul)
        begin
            prod_reg <= 63'(value_reg) * 63'(DIV10_MAGIC);
        end

        if (cw.div)
        begin
            value_reg <= {3'b000, quot};
            for (int p = 0; p < POSITIONS; p++)
            begin
                if (used_reg == 3'(p))
                begin
                    digit_reg[p] <= rem;
                end
            end
        end

        if (cw.finish)
        begin
            ovf_reg <= (value_reg != '0);
            if (used_reg == '0)
            begin
                digit_reg[0] <= 4'd0;
            end
        end

        if (cw.emit && !stall)
        begin
            out_address_reg <= byte_reg;
            out_byte_reg    <= map_byte;
            out_last_reg    <= (byte_reg == LAST_ADDR);
            out_ovf_reg     <= ovf_reg;
        end
    end

    assign grid_out.valid        = out_valid_reg;
    assign grid_out.grid_address = out_address_reg;
    assign grid_out.grid_byte    = out_byte_reg;
    assign grid_out.last_byte    = out_last_reg;
    assign grid_out.overflow     = out_ovf_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= DIGIT_LIMIT)
        else $error("digit count beyond DIGIT_COUNT");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (step_reg == STEP_MUL) && (used_reg == '0))
        else $error("conversion did not start after input transaction");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.emit && ovf_reg) |-> (used_reg == DIGIT_LIMIT))
        else $error("overflow with fewer than DIGIT_COUNT digits");

    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (grid_out.valid && grid_out.last_byte) |-> (grid_out.grid_address == LAST_ADDR))
        else $error("last byte flag on wrong address");
`endif

endmodule

// ----- tb/tb_counter_to_seven_segment_grid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_to_seven_segment_grid: self-checking bench for the counter display
// Feeds signed counter values, predicts the fourteen-byte grid image of each
// one and checks every grid byte in order, under random stalls on both sides.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [3:0] grid_address;
    logic [7:0] grid_byte;
    logic       last_byte;
    logic       overflow;
} grid_beat_t;

// Predicts the grid image of each accepted counter value and checks the
// grid bytes against it in arrival order.
class grid_image_board;
    grid_beat_t expected_bytes[$];
    int         digit_count;
    int         errors;
    int         values_seen;
    int         overflow_values;
    int         bytes_checked;

    function new(int digits);
        digit_count     = digits;
        errors          = 0;
        values_seen     = 0;
        overflow_values = 0;
        bytes_checked   = 0;
    endfunction

    // Segment k of a digit is bit k
    function logic [6:0] lit_segments(logic [3:0] digit);
        case (digit)
            4'd0:    return 7'h7E;
            4'd1:    return 7'h30;
            4'd2:    return 7'h6D;
            4'd3:    return 7'h79;
            4'd4:    return 7'h33;
            4'd5:    return 7'h5B;
            4'd6:    return 7'h5F;
            4'd7:    return 7'h70;
            4'd8:    return 7'h7F;
            default: return 7'h7B;
        endcase
    endfunction

    // Bit that positions 0..4 drive inside an even grid byte
    function int even_bit(int pos);
        case (pos)
            0:       return 2;
            1:       return 3;
            2:       return 4;
            3:       return 5;
            default: return 7;
        endcase
    endfunction

    function void predict_image(logic signed [31:0] count);
        logic [31:0] rest;
        logic [3:0]  digit [6];
        bit          shown [6];
        logic [7:0]  image [14];
        logic [6:0]  segs;
        logic        ovf;
        grid_beat_t  beat;
        int          used;
        int          p;
        int          k;

        // negative counts show as zero
        rest = count[31] ? 32'd0 : count;
        used = 0;
        for (p = 0; p < 6; p++)
        begin
            digit[p] = 4'd0;
            shown[p] = 1'b0;
        end
        while (rest != 0 && used < digit_count)
        begin
            digit[used] = 4'(rest % 10);
            shown[used] = 1'b1;
            rest        = rest / 10;
            used++;
        end
        ovf = (rest != 0);
        if (used == 0)
            shown[0] = 1'b1;

        for (k = 0; k < 14; k++)
            image[k] = 8'h00;
        for (p = 0; p < 6; p++)
        begin
            if (shown[p])
            begin
                segs = lit_segments(digit[p]);
                for (k = 0; k < 7; k++)
                begin
                    if (segs[k])
                    begin
                        // the sixth position lives alone in the odd bytes
                        if (p == 5)
                            image[2*k+1][0] = 1'b1;
                        else
                            image[2*k][even_bit(p)] = 1'b1;
                    end
                end
            end
        end

        for (k = 0; k < 14; k++)
        begin
            beat.grid_address = 4'(k);
            beat.grid_byte    = image[k];
            beat.last_byte    = (k == 13);
            beat.overflow     = ovf;
            expected_bytes.push_back(beat);
        end
        values_seen++;
        if (ovf)
            overflow_values++;
    endfunction

    function void check_byte(grid_beat_t got);
        grid_beat_t want;

        if (expected_bytes.size() == 0)
        begin
            $error("unexpected grid byte: grid_address %0d grid_byte %02h",
                   got.grid_address, got.grid_byte);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got.grid_address !== want.grid_address)
        begin
            $error("grid_address expected %0d actual %0d",
                   want.grid_address, got.grid_address);
            errors++;
        end
        if (got.grid_byte !== want.grid_byte)
        begin
            $error("grid_byte expected %02h actual %02h (address %0d)",
                   want.grid_byte, got.grid_byte, want.grid_address);
            errors++;
        end
        if (got.last_byte !== want.last_byte)
        begin
            $error("last_byte expected %0b actual %0b (address %0d)",
                   want.last_byte, got.last_byte, want.grid_address);
            errors++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow expected %0b actual %0b (address %0d)",
                   want.overflow, got.overflow, want.grid_address);
            errors++;
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module tb_counter_to_seven_segment_grid;

    localparam int DIGITS        = 6;
    localparam int RANDOM_ITEMS  = 70;
    localparam int CLEAN_ITEMS   = 20;
    localparam int BURST_ITEMS   = 8;
    // long receiver hold-off; well under the watchdog limit
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;

    logic clk;
    logic rst_n;

    c7s_count_if count_ch ();
    c7s_grid_if  grid_ch ();

    counter_to_seven_segment_grid #(
        .DIGIT_COUNT (DIGITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .count_in (count_ch),
        .grid_out (grid_ch)
    );

    grid_image_board board;

    // Random idling on both sides; cleared for the final stretch
    bit idling_on;
    // Set by the stimulus to ask the receiver for one long hold-off
    bit hold_request;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample handshakes at the rising edge, before any update of
    // that edge lands, so both sides see the same transaction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && count_ch.valid && count_ch.ready)
            board.predict_image(count_ch.count_value);
    end

    always @(posedge clk)
    begin
        grid_beat_t got;
        if (rst_n && grid_ch.valid && grid_ch.ready)
        begin
            got.grid_address = grid_ch.grid_address;
            got.grid_byte    = grid_ch.grid_byte;
            got.last_byte    = grid_ch.last_byte;
            got.overflow     = grid_ch.overflow;
            board.check_byte(got);
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction
    always @(posedge clk)
    begin
        if ((count_ch.valid && count_ch.ready) || (grid_ch.valid && grid_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d grid bytes outstanding",
                     STALL_LIMIT, board.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready runs of random length, stall bursts of random length,
    // and one long hold-off on request. One assignment per iteration, and
    // every iteration advances time.
    // ------------------------------------------------------------------------
    initial
    begin
        grid_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                grid_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 2) == 0)
            begin
                grid_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                grid_ch.ready <= 1'b1;
                // occasionally a long clean stretch
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(30, 80)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one counter value and hold it until taken. Valid stays high
    // into the next call unless an idle burst follows.
    task automatic send_count(input logic signed [31:0] value);
        count_ch.valid       <= 1'b1;
        count_ch.count_value <= value;
        @(posedge clk);
        while (!count_ch.ready)
            @(posedge clk);
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            count_ch.valid       <= 1'b0;
            count_ch.count_value <= $urandom;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Draw a counter value; weight toward values of every digit length,
    // the overflow boundary, trailing zeros and the sign bit.
    function automatic logic signed [31:0] pick_count();
        logic [31:0] value;
        int          limit;
        int          n;

        case ($urandom_range(0, 9))
            0, 1:
            begin
                value = $urandom;
            end
            2, 3, 4:
            begin
                // uniform over a random digit length
                n     = $urandom_range(1, 6);
                limit = 1;
                repeat (n) limit = limit * 10;
                value = $urandom_range(0, limit - 1);
            end
            5:
            begin
                // straddle the six-digit limit
                if ($urandom_range(0, 1) == 0)
                    value = 999_990 + $urandom_range(0, 20);
                else
                    value = 1_000_000 * $urandom_range(1, 2147) + $urandom_range(0, 99);
            end
            6:
            begin
                // set the sign bit, rest random
                value = $urandom | 32'h8000_0000;
            end
            7:
            begin
                // single digit followed by zeros
                n     = $urandom_range(0, 9);
                value = $urandom_range(1, 9);
                repeat (n) value = value * 10;
            end
            8:
            begin
                value = $urandom_range(0, 20);
            end
            default:
            begin
                value = -$urandom_range(1, 1000);
            end
        endcase
        return value;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_count(pick_count());
    endtask

    // Let the input monitor log the last transaction, then wait for the
    // grid image queue to empty.
    task automatic wait_drained();
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        board                = new(DIGITS);
        rst_n                = 1'b0;
        count_ch.valid       = 1'b0;
        count_ch.count_value = '0;
        idling_on            = 1'b1;
        hold_request         = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, negatives, extremes, every digit value, blanking
        // at each length, and the values just past six digits.
        send_count(32'sd0);
        send_count(32'sd1);
        send_count(-32'sd1);
        send_count(-32'sd2147483648);
        send_count(32'sd2147483647);
        send_count(32'sd9);
        send_count(32'sd10);
        send_count(32'sd99);
        send_count(32'sd100);
        send_count(32'sd1000);
        send_count(32'sd10000);
        send_count(32'sd100000);
        send_count(32'sd999999);
        send_count(32'sd1000000);
        send_count(32'sd1000001);
        send_count(32'sd123456);
        send_count(32'sd987654);
        send_count(32'sd102030);
        send_count(32'sd900009);
        send_count(32'sd857);
        send_count(32'sd123456789);
        send_count(-32'sd5);

        // Hold the receiver off while offering values back to back, so the
        // block fills and stalls its input.
        hold_request = 1'b1;
        idling_on    = 1'b0;
        repeat (BURST_ITEMS) send_count(pick_count());
        idling_on    = 1'b1;

        // Pause the sender until every grid byte has come out
        count_ch.valid <= 1'b0;
        wait_drained();

        run_random(RANDOM_ITEMS);

        // Final stretch with no idling on either side
        idling_on = 1'b0;
        run_random(CLEAN_ITEMS);
        count_ch.valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        board.errors = board.errors + board.pending();
        $display("Covered %0d counter values (%0d past six digits), %0d grid bytes checked,",
                 board.values_seen, board.overflow_values, board.bytes_checked);
        $display("including one long receiver hold-off and one full drain pause.");
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/c7s_pkg.sv
hdl/c7s_if.sv
hdl/c7s_grid_map.sv
hdl/counter_to_seven_segment_grid.sv
tb/tb_counter_to_seven_segment_grid.sv
